// ===== sv/fidc_pkg.sv =====
// ---------------------------------------------------------------------------
// fidc_pkg
// Shared types, constants and the CRC-32 byte update for the frame checker.
// ---------------------------------------------------------------------------
package fidc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned IDENT_W     = 64;
    localparam int unsigned CRC_W       = 32;
    localparam int unsigned POS_W       = 8;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned DLY_DEPTH   = 4;
    localparam int unsigned MAX_FRAME_D = 255;

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [POS_W-1:0] IDENT_LEN   = 8'd8;
    localparam logic [POS_W-1:0] CRC_START   = 8'd4;
    localparam logic [POS_W-1:0] MIN_FRAME   = 8'd12;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_ID    = 3'd1,
        ST_CRC   = 3'd2,
        ST_SHORT = 3'd3,
        ST_LONG  = 3'd4
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_valid;
        logic              frame_done;
        status_t           frame_status;
    } result_t;

    // reflected CRC-32, one byte, bitwise unrolled
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = c_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/fidc_frame_core.sv =====
// ---------------------------------------------------------------------------
// fidc_frame_core
// Per-frame state: position count, ident match, running CRC and trailer
// delay line. Produces one result per stepped word.
// ---------------------------------------------------------------------------
module fidc_frame_core #(
    parameter int unsigned MAX_FRAME = fidc_pkg::MAX_FRAME_D
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fidc_pkg::IDENT_W-1:0]  cfg_wr_data,
    input  logic                          step,
    input  logic [fidc_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          last_byte,
    output fidc_pkg::result_t             result
);
    import fidc_pkg::*;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME);

    logic [IDENT_W-1:0] group_ident_reg;
    logic [POS_W-1:0]   pos_reg, pos_next, pos_upd;
    logic               ovf_reg, ovf_next, ovf_upd;
    logic               id_reg, id_next, id_upd;
    logic [CRC_W-1:0]   crc_reg, crc_next, crc_upd;
    logic [BYTE_W-1:0]  dly_reg  [DLY_DEPTH];
    logic [BYTE_W-1:0]  dly_next [DLY_DEPTH];
    logic [BYTE_W-1:0]  want;
    logic [CRC_W-1:0]   got;

    assign want = group_ident_reg[{pos_reg[2:0], 3'b000} +: BYTE_W];
    assign got  = {dly_next[3], dly_next[2], dly_next[1], dly_next[0]};

    always_comb begin
        pos_upd  = pos_reg;
        ovf_upd  = ovf_reg;
        id_upd   = id_reg;
        crc_upd  = crc_reg;
        dly_next = dly_reg;
        result   = '0;
        if (step) begin
            if (pos_reg >= MAX_POS) begin
                ovf_upd = 1'b1;
            end else if (!ovf_reg) begin
                if (pos_reg < IDENT_LEN && want != rx_byte) begin
                    id_upd = 1'b0;
                end
                if (pos_reg >= CRC_START) begin
                    crc_upd = crc_byte(crc_reg, dly_reg[0]);
                    if (pos_reg >= MIN_FRAME) begin
                        result.payload_byte  = dly_reg[0];
                        result.payload_valid = 1'b1;
                    end
                end
                dly_next[0] = dly_reg[1];
                dly_next[1] = dly_reg[2];
                dly_next[2] = dly_reg[3];
                dly_next[3] = rx_byte;
                pos_upd     = pos_reg + 1'b1;
            end
            if (last_byte) begin
                result.frame_done = 1'b1;
                if (ovf_upd) begin
                    result.frame_status = ST_LONG;
                end else if (pos_upd < MIN_FRAME) begin
                    result.frame_status = ST_SHORT;
                end else if (!id_upd) begin
                    result.frame_status = ST_ID;
                end else if (~crc_upd == got) begin
                    result.frame_status = ST_OK;
                end else begin
                    result.frame_status = ST_CRC;
                end
            end
        end
    end

    // clear per-frame state after the last word
    always_comb begin
        pos_next = pos_upd;
        ovf_next = ovf_upd;
        id_next  = id_upd;
        crc_next = crc_upd;
        if (step && last_byte) begin
            pos_next = '0;
            ovf_next = 1'b0;
            id_next  = 1'b1;
            crc_next = CRC_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_ident_reg <= '0;
            pos_reg         <= '0;
            ovf_reg         <= 1'b0;
            id_reg          <= 1'b1;
            crc_reg         <= CRC_INIT;
        end else begin
            if (cfg_wr_en) begin
                group_ident_reg <= cfg_wr_data;
            end
            pos_reg <= pos_next;
            ovf_reg <= ovf_next;
            id_reg  <= id_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        dly_reg <= dly_next;
    end

endmodule

// ===== sv/frame_id_crc_checker.sv =====
// ---------------------------------------------------------------------------
// frame_id_crc_checker
// Group-ident and CRC-32 check of received frames, one byte word at a time.
// ---------------------------------------------------------------------------
// Takes one frame byte per word with a last-byte flag and returns one result
// word per input word, at a sustained rate of one word per cycle while m_ready
// stays high. Timing is set by an input register and a result register
// with a single-pass byte-wide CRC update and status compare between them.
// Payload bytes are tentative; keep them only if the frame_done word reports
// status ok. Payload lags input by four bytes, so the trailer never appears.
module frame_id_crc_checker #(
    parameter int unsigned MAX_FRAME = fidc_pkg::MAX_FRAME_D
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fidc_pkg::IDENT_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fidc_pkg::BYTE_W-1:0]   s_rx_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fidc_pkg::BYTE_W-1:0]   m_payload_byte,
    output logic                          m_payload_valid,
    output logic                          m_frame_done,
    output logic [fidc_pkg::STATUS_W-1:0] m_frame_status
);
    import fidc_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           core_result;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    fidc_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .last_byte   (in_last_reg),
        .result      (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
            in_last_reg <= s_last_byte;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_payload_valid = out_reg.payload_valid;
    assign m_frame_done    = out_reg.frame_done;
    assign m_frame_status  = out_reg.frame_status;

endmodule
